// ===== hw/rtl/battery_runtime_estimator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Battery runtime estimator assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_RUNTIME_ESTIMATOR_CORE_MACROS_SVH
`define BATTERY_RUNTIME_ESTIMATOR_CORE_MACROS_SVH

// Property checked at every rising edge outside reset.
`define BRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked at every rising edge outside reset.
`define BRT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/brt_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery runtime estimator package
// Shared constants, types and state codes of the estimator.
// ----------------------------------------------------------------------------
package brt_pkg;

  localparam int unsigned HistDepthDef = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DivNumW = 76;
  localparam int unsigned DivDenW = 64;
  localparam int unsigned DivQW   = 17;

  localparam logic [14:0] LevelFull  = 15'd25600;
  localparam logic [14:0] EtaNone    = 15'h7FFF;
  localparam logic [14:0] EtaMax     = 15'd10000;
  localparam logic [16:0] RateSat    = 17'd65536;
  localparam logic [16:0] RateQLimit = 17'd68400;
  localparam logic [31:0] SecPerHour = 32'd3600;
  localparam logic [31:0] EtaCap     = 32'd10000;
  localparam logic [31:0] MinPerHour = 32'd60;
  localparam logic [31:0] MinTwice   = 32'd120;

  typedef enum logic [2:0] {
    CFG_MIN_SAMPLES    = 3'd0,
    CFG_MIN_SPAN       = 3'd1,
    CFG_MAX_DROP       = 3'd2,
    CFG_MAX_RECOVERY   = 3'd3,
    CFG_MIN_RATE       = 3'd4,
    CFG_MAX_RATE       = 3'd5,
    CFG_MIN_EST_DROP   = 3'd6
  } brt_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EST, ST_OLD, ST_T, ST_TT, ST_TQ, ST_TP,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
    ST_DIVR, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6, ST_DIVE, ST_OUT
  } brt_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } brt_div_stat_t;

endpackage

// ===== hw/rtl/brt_ring.sv =====
// ----------------------------------------------------------------------------
// Sample history ring
// Time and level memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brt_ring import brt_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistDepthDef,
  localparam int unsigned IdxW = $clog2(HISTORY_DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [31:0]     wtime_i,
  input  logic [14:0]     wlevel_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [31:0]     rtime_o,
  output logic [14:0]     rlevel_o
);

  logic [31:0] time_mem [HISTORY_DEPTH];
  logic [14:0] level_mem [HISTORY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i]  <= wtime_i;
      level_mem[waddr_i] <= wlevel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rtime_o  <= time_mem[raddr_i];
    rlevel_o <= level_mem[raddr_i];
  end

endmodule

// ===== hw/rtl/brt_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// One 32 by 32 bit unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module brt_mul import brt_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= 64'(a_i) * 64'(b_i);
  end

endmodule

// ===== hw/rtl/brt_div.sv =====
// ----------------------------------------------------------------------------
// Shared divider
// Restoring divider, one quotient bit a cycle, that flags a quotient overflow.
// ----------------------------------------------------------------------------
module brt_div import brt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output brt_div_stat_t      stat_o,
  output logic [DivQW-1:0]   quot_o,
  output logic               ovf_o
);

  localparam int unsigned CntW = $clog2(DivNumW);

  logic               busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DivDenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivQW-1:0]   quot_q, quot_d;
  logic               ovf_q, ovf_d;
  logic [DivDenW:0]   trial;
  logic               ge;

  assign trial = {rem_q, num_q[DivNumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivNumW - 1);
      rem_d  = '0;
      den_d  = den_i;
      num_d  = num_i;
      quot_d = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      rem_d  = ge ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      num_d  = {num_q[DivNumW-2:0], 1'b0};
      ovf_d  = ovf_q | quot_q[DivQW-1];
      quot_d = {quot_q[DivQW-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

// ===== hw/rtl/battery_runtime_estimator_core.sv =====
// A sample that clears or skips the history, or meets too few samples or too
// short a span, gets no estimate; otherwise each of the n samples in the
// ring goes in turn through the shared multiplier, and slope and runtime then
// take two passes through the shared divider. One item at a time.
// Reset clears control state and loads register defaults; the ring needs no
// clearing pass, since only entries below the fill count are read.
// ----------------------------------------------------------------------------
// Battery runtime estimator
// Filters charge samples, fits a least-squares slope over the history ring
// and derives the minutes of runtime left.
// ----------------------------------------------------------------------------
`include "battery_runtime_estimator_core_macros.svh"

module battery_runtime_estimator_core import brt_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         uptime_seconds_i,
  input  logic [14:0]         charge_level_i,
  input  logic                on_charger_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [14:0]  eta_minutes_o
);

  localparam int unsigned IdxW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);

  // Configuration registers.
  logic [8:0]  min_cnt_q;
  logic [15:0] min_span_q;
  logic [14:0] max_drop_q;
  logic [14:0] max_rec_q;
  logic [15:0] min_rate_q;
  logic [15:0] max_rate_q;
  logic [14:0] min_edrop_q;

  brt_state_e state_q, state_d;

  logic [CntW-1:0] fill_q, fill_d, cnt_q, cnt_d;
  logic [IdxW-1:0] slot_q, slot_d, idx_q, idx_d;
  logic            primed_q, primed_d, wasch_q, wasch_d;
  logic [14:0]     filt_q, filt_d, last_q, last_d, lvl_q, lvl_d, p_q, p_d, eta_q, eta_d;
  logic [31:0]     now_q, now_d, told_q, told_d, elap_q, elap_d, st_q, st_d;
  logic [23:0]     t_q, t_d;
  logic [22:0]     sp_q, sp_d;
  logic [63:0]     stt_q, stt_d, stp_q, stp_d, den_q, den_d, acc_q, acc_d, aux_q, aux_d;
  logic [16:0]     rate_q, rate_d;

  // Sample preprocessing.
  logic [14:0]     lvl_sat, f_prim, f_new, f0;
  logic [16:0]     sum3;
  logic [15:0]     cap, f1;
  logic [CntW-1:0] eff_fill;
  logic [IdxW-1:0] eff_slot, slot_inc, oldest, idx_inc;
  logic            eff_primed, big_drop;
  logic [31:0]     t_diff;

  // Shared units.
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  brt_div_stat_t      div_stat;
  logic [DivQW-1:0]   div_quot;
  logic               div_ovf;
  logic               mem_we;
  logic [IdxW-1:0]    raddr;
  logic [31:0]        rd_time;
  logic [14:0]        rd_level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cnt_q   <= 9'd12;
      min_span_q  <= 16'd900;
      max_drop_q  <= 15'd2048;
      max_rec_q   <= 15'd51;
      min_rate_q  <= 16'd64;
      max_rate_q  <= 16'd20480;
      min_edrop_q <= 15'd384;
    end else if (cfg_valid_i) begin
      case (brt_cfg_e'(cfg_index_i))
        CFG_MIN_SAMPLES:  min_cnt_q   <= cfg_data_i[8:0];
        CFG_MIN_SPAN:     min_span_q  <= cfg_data_i;
        CFG_MAX_DROP:     max_drop_q  <= cfg_data_i[14:0];
        CFG_MAX_RECOVERY: max_rec_q   <= cfg_data_i[14:0];
        CFG_MIN_RATE:     min_rate_q  <= cfg_data_i;
        CFG_MAX_RATE:     max_rate_q  <= cfg_data_i;
        CFG_MIN_EST_DROP: min_edrop_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign lvl_sat    = (charge_level_i > LevelFull) ? LevelFull : charge_level_i;
  assign eff_fill   = wasch_q ? '0 : fill_q;
  assign eff_slot   = wasch_q ? '0 : slot_q;
  assign eff_primed = wasch_q ? 1'b0 : primed_q;
  assign sum3       = 17'(filt_q) + 17'({filt_q, 1'b0}) + 17'(lvl_sat);
  assign f0         = sum3[16:2];
  assign cap        = 16'(filt_q) + 16'(max_rec_q);
  assign f1         = (16'(f0) > cap) ? cap : 16'(f0);
  assign f_prim     = (f1 > 16'(LevelFull)) ? LevelFull : f1[14:0];
  assign f_new      = eff_primed ? f_prim : lvl_sat;
  // The level stored last is only meaningful while the ring holds samples.
  assign big_drop   = (eff_fill != '0) && (last_q > f_new) && ((last_q - f_new) > max_drop_q);
  assign slot_inc   = (eff_slot == IdxW'(HISTORY_DEPTH - 1)) ? '0 : eff_slot + 1'b1;
  assign oldest     = (fill_q < CntW'(HISTORY_DEPTH)) ? '0 : slot_q;
  assign idx_inc    = (idx_q == IdxW'(HISTORY_DEPTH - 1)) ? '0 : idx_q + 1'b1;
  assign t_diff     = rd_time - told_q;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    slot_d    = slot_q;
    primed_d  = primed_q;
    wasch_d   = wasch_q;
    filt_d    = filt_q;
    last_d    = last_q;
    lvl_d     = lvl_q;
    now_d     = now_q;
    told_d    = told_q;
    elap_d    = elap_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    t_d       = t_q;
    p_d       = p_q;
    st_d      = st_q;
    sp_d      = sp_q;
    stt_d     = stt_q;
    stp_d     = stp_q;
    den_d     = den_q;
    acc_d     = acc_q;
    aux_d     = aux_q;
    rate_d    = rate_q;
    eta_d     = eta_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mem_we    = 1'b0;
    raddr     = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          eta_d   = EtaNone;
          state_d = ST_OUT;
          if (on_charger_i || lvl_sat == '0) begin
            fill_d   = '0;
            slot_d   = '0;
            primed_d = 1'b0;
            wasch_d  = on_charger_i;
          end else if (big_drop) begin
            fill_d   = '0;
            slot_d   = '0;
            primed_d = 1'b0;
            wasch_d  = 1'b0;
          end else begin
            mem_we   = 1'b1;
            wasch_d  = 1'b0;
            primed_d = 1'b1;
            filt_d   = f_new;
            last_d   = f_new;
            lvl_d    = f_new;
            now_d    = uptime_seconds_i;
            slot_d   = slot_inc;
            fill_d   = (eff_fill < CntW'(HISTORY_DEPTH)) ? eff_fill + 1'b1 : eff_fill;
            state_d  = ST_EST;
          end
        end
      end
      ST_EST: begin
        raddr = oldest;
        idx_d = oldest;
        if (32'(fill_q) < 32'(min_cnt_q)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_OLD;
        end
      end
      ST_OLD: begin
        elap_d = now_q - rd_time;
        told_d = rd_time;
        st_d   = '0;
        sp_d   = '0;
        stt_d  = '0;
        stp_d  = '0;
        cnt_d  = '0;
        if ((now_q - rd_time) < 32'(min_span_q)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_T;
        end
      end
      ST_T: begin
        t_d = t_diff[23:0];
        p_d = rd_level;
        // Samples too far from the oldest would overflow the sums.
        if (t_diff[31:24] != '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_TT;
        end
      end
      ST_TT: begin
        mul_a   = 32'(t_q);
        mul_b   = 32'(t_q);
        state_d = ST_TQ;
      end
      ST_TQ: begin
        stt_d   = stt_q + prod;
        st_d    = st_q + 32'(t_q);
        sp_d    = sp_q + 23'(p_q);
        mul_a   = 32'(t_q);
        mul_b   = 32'(p_q);
        state_d = ST_TP;
      end
      ST_TP: begin
        stp_d = stp_q + prod;
        if (cnt_q + 1'b1 == fill_q) begin
          state_d = ST_M1;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          idx_d   = idx_inc;
          raddr   = idx_inc;
          state_d = ST_T;
        end
      end
      ST_M1: begin
        mul_a   = 32'(fill_q);
        mul_b   = stt_q[31:0];
        state_d = ST_M2;
      end
      ST_M2: begin
        acc_d   = prod;
        mul_a   = 32'(fill_q);
        mul_b   = stt_q[63:32];
        state_d = ST_M3;
      end
      ST_M3: begin
        acc_d   = acc_q + {prod[31:0], 32'd0};
        mul_a   = st_q;
        mul_b   = st_q;
        state_d = ST_M4;
      end
      ST_M4: begin
        den_d   = acc_q - prod;
        mul_a   = 32'(fill_q);
        mul_b   = stp_q[31:0];
        state_d = ((acc_q - prod) == '0) ? ST_OUT : ST_M5;
      end
      ST_M5: begin
        acc_d   = prod;
        mul_a   = 32'(fill_q);
        mul_b   = stp_q[63:32];
        state_d = ST_M6;
      end
      ST_M6: begin
        acc_d   = acc_q + {prod[31:0], 32'd0};
        mul_a   = st_q;
        mul_b   = 32'(sp_q);
        state_d = ST_M7;
      end
      ST_M7: begin
        // A flat or rising fit gives no estimate.
        acc_d   = prod - acc_q;
        state_d = (prod <= acc_q) ? ST_OUT : ST_M8;
      end
      ST_M8: begin
        mul_a   = acc_q[31:0];
        mul_b   = SecPerHour;
        state_d = ST_M9;
      end
      ST_M9: begin
        aux_d   = prod;
        mul_a   = acc_q[63:32];
        mul_b   = SecPerHour;
        state_d = ST_M10;
      end
      ST_M10: begin
        div_start = 1'b1;
        div_num   = DivNumW'(aux_q) + (DivNumW'(prod) << 32);
        div_den   = den_q;
        state_d   = ST_DIVR;
      end
      ST_DIVR: begin
        if (div_stat.done) begin
          rate_d  = (div_ovf || div_quot >= RateQLimit) ? RateSat : div_quot;
          state_d = ST_R1;
        end
      end
      ST_R1: begin
        mul_a   = 32'(min_edrop_q);
        mul_b   = SecPerHour;
        state_d = (rate_q < 17'(min_rate_q) || rate_q > 17'(max_rate_q)) ? ST_OUT : ST_R2;
      end
      ST_R2: begin
        acc_d   = prod;
        mul_a   = 32'(rate_q);
        mul_b   = elap_q;
        state_d = ST_R3;
      end
      ST_R3: begin
        mul_a   = 32'(lvl_q);
        mul_b   = MinPerHour;
        state_d = (prod < acc_q || rate_q == '0) ? ST_OUT : ST_R4;
      end
      ST_R4: begin
        acc_d   = prod;
        mul_a   = 32'(rate_q);
        mul_b   = EtaCap;
        state_d = ST_R5;
      end
      ST_R5: begin
        mul_a   = 32'(lvl_q);
        mul_b   = MinTwice;
        state_d = (acc_q >= prod) ? ST_OUT : ST_R6;
      end
      ST_R6: begin
        // Rounded half up: (120 * level + rate) / (2 * rate).
        div_start = 1'b1;
        div_num   = DivNumW'(prod) + DivNumW'(rate_q);
        div_den   = DivDenW'({rate_q, 1'b0});
        state_d   = ST_DIVE;
      end
      ST_DIVE: begin
        if (div_stat.done) begin
          eta_d   = div_quot[14:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      slot_q   <= '0;
      primed_q <= 1'b0;
      wasch_q  <= 1'b0;
      filt_q   <= '0;
    end else begin
      fill_q   <= fill_d;
      slot_q   <= slot_d;
      primed_q <= primed_d;
      wasch_q  <= wasch_d;
      filt_q   <= filt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    lvl_q  <= lvl_d;
    now_q  <= now_d;
    told_q <= told_d;
    elap_q <= elap_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    t_q    <= t_d;
    p_q    <= p_d;
    st_q   <= st_d;
    sp_q   <= sp_d;
    stt_q  <= stt_d;
    stp_q  <= stp_d;
    den_q  <= den_d;
    acc_q  <= acc_d;
    aux_q  <= aux_d;
    rate_q <= rate_d;
    eta_q  <= eta_d;
  end

  assign eta_minutes_o = $signed(eta_q);

  brt_ring #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (eff_slot),
    .wtime_i  (uptime_seconds_i),
    .wlevel_i (f_new),
    .raddr_i  (raddr),
    .rtime_o  (rd_time),
    .rlevel_o (rd_level)
  );

  brt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  brt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot),
    .ovf_o   (div_ovf)
  );

  `BRT_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= CntW'(HISTORY_DEPTH), "fill count past depth")
  `BRT_ASSERT_IMP(a_div_free, clk_i, rst_ni, div_start, !div_stat.busy, "divider restarted while busy")
  `BRT_ASSERT_IMP(a_eta_range, clk_i, rst_ni, out_valid_o && eta_q != EtaNone, eta_q <= EtaMax, "estimate out of range")
  `BRT_ASSERT(a_one_side, clk_i, rst_ni, !(in_ready_o && out_valid_o), "input taken while result pending")

endmodule
